/* src/srl_pkg.sv */
`timescale 1ns / 1ps
// srl_pkg: types and constants shared by the stereo linear resampler
// no dependencies

package srl_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP = 2'd1;

    localparam logic [1:0] MODE_PASS     = 2'd0;
    localparam logic [1:0] MODE_RESAMPLE = 2'd1;

    localparam longint unsigned RATE_IN_HZ  = 44100;
    localparam longint unsigned RATE_OUT_HZ = 48000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_MUL_L,
        ST_MUL_R,
        ST_EMIT
    } srl_state_t;

endpackage

/* src/stereo_linear_resampler_top.sv */
`timescale 1ns / 1ps
// stereo_linear_resampler_top: stereo linear interpolation resampler
// depends on srl_pkg
//
// one stereo frame comes in on the s_ channel, zero to two frames leave on the m_ channel.
// m_tlast marks the final output frame caused by an input item.
// passthrough: one output frame, stored into the output register from the pass state.
// resample: one shared multiplier does both channels of each output frame in turn,
// the left product in ST_MUL_L and the right in ST_MUL_R, with the frame stored from ST_EMIT;
// a second output frame of the same item goes round again from ST_MUL_L.
// discard: the item is taken and gives no output.
// s_tready is high only while the sequencer is idle; one item is worked at a time.
// the output register holds a finished frame while the receiver stalls; the sequencer
// waits in its pass or emit state until the frame ahead has been taken, and the next input
// item may be accepted while the last frame still waits.
// configuration writes take effect at once and must only come while the block is idle.
// reset clears phase, previous-frame flag, mode (passthrough) and the step (44.1k/48k).

module stereo_linear_resampler_top #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // s_tdata: left_sample, right_sample
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,
    // s_tuser: stream_start
    input  logic [0:0]                              s_tuser,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // m_tdata: left_out, right_out
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     m_tdata,
    output logic                                    m_tlast,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic                                    cfg_we,
    input  logic [srl_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [srl_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import srl_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int DATA_W = ((2*SW+7)/8)*8;
    localparam int PROD_W = SW + F + 2;

    localparam logic [F-1:0] MIN_STEP   = {1'b1, {(F-1){1'b0}}};
    localparam logic [F-1:0] STEP_RESET = F'((RATE_IN_HZ << F) / RATE_OUT_HZ);

    srl_state_t state_reg, state_next;

    logic [1:0]   mode_reg;
    logic [F-1:0] step_reg;
    logic [F-1:0] phase_reg;
    logic         have_prev_reg;
    logic [F-1:0] pos_reg;
    logic         cnt_reg;

    logic [SW-1:0] prev_l_reg, prev_r_reg;
    logic [SW-1:0] cur_l_reg, cur_r_reg;
    logic [SW-1:0] s0_l_reg, s0_r_reg;
    logic [SW:0]   d_l_reg, d_r_reg;
    logic [SW-1:0] res_l_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic [DATA_W-1:0] m_tdata_reg;
    logic              m_tlast_reg;
    logic              m_tvalid_reg;

    logic [SW-1:0] in_l, in_r, sel_l, sel_r;
    logic          in_start, in_acc, slot_free, emit, emit_last;
    logic [F-1:0]  step_eff;
    logic [F:0]    pos_sum;
    logic signed [SW:0]   mul_a;
    logic signed [F:0]    mul_b;
    logic signed [PROD_W-1:0] prod_w, prod_sh;
    logic [SW-1:0] res_r;
    logic [DATA_W-1:0] out_data;

    assign in_l     = s_tdata[SW-1:0];
    assign in_r     = s_tdata[2*SW-1:SW];
    assign in_start = s_tuser[0];
    assign sel_l    = (have_prev_reg && !in_start) ? prev_l_reg : in_l;
    assign sel_r    = (have_prev_reg && !in_start) ? prev_r_reg : in_r;

    assign step_eff  = (step_reg < MIN_STEP) ? MIN_STEP : step_reg;
    assign pos_sum   = {1'b0, pos_reg} + {1'b0, step_eff};
    assign emit_last = pos_sum[F] || cnt_reg;
    assign slot_free = !m_tvalid_reg || m_tready;

    // shared multiplier
    assign mul_a   = (state_reg == ST_MUL_L) ? $signed(d_l_reg) : $signed(d_r_reg);
    assign mul_b   = $signed({1'b0, pos_reg});
    assign prod_w  = mul_a * mul_b;
    assign prod_sh = prod_reg >>> F;
    assign res_r   = s0_r_reg + prod_sh[SW-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (mode_reg == MODE_PASS)
                        state_next = ST_PASS;
                    else if (mode_reg == MODE_RESAMPLE)
                        state_next = ST_MUL_L;
                end
            end
            ST_PASS:  if (slot_free) state_next = ST_IDLE;
            ST_MUL_L: state_next = ST_MUL_R;
            ST_MUL_R: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (slot_free)
                    state_next = emit_last ? ST_IDLE : ST_MUL_L;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        emit     = 1'b0;
        out_data = '0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_PASS:
            begin
                emit = slot_free;
                out_data[2*SW-1:0] = {cur_r_reg, cur_l_reg};
            end
            ST_EMIT:
            begin
                emit = slot_free;
                out_data[2*SW-1:0] = {res_r, res_l_reg};
            end
            default: s_tready = 1'b0;
        endcase
    end

    assign in_acc = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_PASS;
            step_reg      <= STEP_RESET;
            phase_reg     <= '0;
            have_prev_reg <= 1'b0;
            pos_reg       <= '0;
            cnt_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index == CFG_RATE_MODE)
                mode_reg <= cfg_data[1:0];
            if (cfg_we && cfg_index == CFG_PHASE_STEP)
                step_reg <= F'(cfg_data);
            if (in_acc)
            begin
                pos_reg <= in_start ? '0 : phase_reg;
                cnt_reg <= 1'b0;
                if (in_start)
                begin
                    phase_reg     <= '0;
                    have_prev_reg <= 1'b0;
                end
            end
            else if (emit && state_reg == ST_EMIT)
            begin
                pos_reg <= pos_sum[F-1:0];
                cnt_reg <= 1'b1;
                if (emit_last)
                begin
                    phase_reg     <= pos_sum[F-1:0];
                    have_prev_reg <= 1'b1;
                end
            end
            if (emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cur_l_reg <= in_l;
            cur_r_reg <= in_r;
            s0_l_reg  <= sel_l;
            s0_r_reg  <= sel_r;
            d_l_reg   <= {in_l[SW-1], in_l} - {sel_l[SW-1], sel_l};
            d_r_reg   <= {in_r[SW-1], in_r} - {sel_r[SW-1], sel_r};
        end
        if (state_reg == ST_MUL_L || state_reg == ST_MUL_R)
            prod_reg <= prod_w;
        if (state_reg == ST_MUL_R)
            res_l_reg <= s0_l_reg + prod_sh[SW-1:0];
        if (emit && state_reg == ST_EMIT && emit_last)
        begin
            prev_l_reg <= cur_l_reg;
            prev_r_reg <= cur_r_reg;
        end
        if (emit)
        begin
            m_tdata_reg <= out_data;
            m_tlast_reg <= (state_reg == ST_PASS) ? 1'b1 : emit_last;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tvalid = m_tvalid_reg;

    // second output frame of an item always crosses a whole input frame
    a_second_crosses: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && cnt_reg) |-> pos_sum[F])
        else $error("second output frame without phase wrap");

    // previous frame becomes valid only on the last resampled frame of an item
    a_prev_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(have_prev_reg) |-> $past(emit && state_reg == ST_EMIT && emit_last))
        else $error("previous frame taken outside last emission");

    // a stalled output frame is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |-> !emit)
        else $error("output frame overwritten while stalled");

endmodule
